/* sv/ple_pkg.sv */
// Package with shared types and constants of the positional list engine.
`timescale 1ns / 1ps

package ple_pkg;

    localparam int PLE_DEPTH   = 16;
    localparam int DATA_W      = 32;
    localparam int POS_W       = 4;
    localparam int CNT_OUT_W   = 5;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_READ   = 2'd1,
        OP_DELETE = 2'd2,
        OP_NONE   = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_WR,
        S_INS_TOP,
        S_DEL_RD,
        S_DEL_WR,
        S_RD_WAIT,
        S_FINISH
    } t_state;

endpackage

/* sv/ple_mem.sv */
// Entry store of the list: one write port and one registered read port.
`timescale 1ns / 1ps

module ple_mem #(
    parameter int DEPTH  = ple_pkg::PLE_DEPTH,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [ADDR_W-1:0]          i_waddr,
    input  logic [ple_pkg::DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0]          i_raddr,
    output logic [ple_pkg::DATA_W-1:0] o_rdata
);
    import ple_pkg::*;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/positional_list_engine.sv */
// Top level of the positional list engine: sequencer, index unit and result register.
`timescale 1ns / 1ps

// Ordered list of signed 32-bit words with insert at front, read and delete at
// a position. One item enters on the s_axis group and one result leaves on the
// m_axis group for every item.
// Only one item is in work at a time: s_axis_tready is high while the
// sequencer is idle. Entries are moved one at a time through the one write
// port and one read port of the entry store, a read state and then a write
// state per moved entry, with one shared index incrementer/decrementer
// stepping the position. A read passes through a wait state; an insert moves
// each entry one place back, then writes the new word at the front; a delete
// pulls each following entry forward; a rejected operation goes straight to finish.
// The next item is taken in the cycle after the result is loaded into the
// output register, so a result may wait there while the next item runs.
// A synchronous active-low reset empties the list and drops m_axis_tvalid;
// stored words are not cleared and are never read before being written.
// When the receiver stalls, the result holds in the output register and a
// following item completes its work, then waits until that register frees up.

module positional_list_engine #(
    parameter int DEPTH = ple_pkg::PLE_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [1:0] opcode, [33:2] value, [37:34] position, [39:38] zero
    input  logic [ple_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [1:0] status, [33:2] read_value, [38:34] entry_count, [39] zero
    output logic [ple_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import ple_pkg::*;

    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    t_state            r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [AW-1:0]     r_idx, n_idx;
    logic [DATA_W-1:0] r_val, n_val;
    t_status           r_status, n_status;
    logic [DATA_W-1:0] r_rdval, n_rdval;
    logic              r_ovalid, n_ovalid;
    logic [OUT_TDATA_W-1:0] r_odata, n_odata;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic [AW-1:0]     mem_raddr;
    logic [DATA_W-1:0] mem_rdata;

    t_opcode           in_op;
    logic [DATA_W-1:0] in_val;
    logic [POS_W-1:0]  in_pos;
    logic              pos_bad;
    logic [AW-1:0]     idx_step;
    logic              idx_dec;
    logic              out_free;

    assign in_op  = t_opcode'(s_axis_tdata[1:0]);
    assign in_val = s_axis_tdata[DATA_W+1:2];
    assign in_pos = s_axis_tdata[DATA_W+POS_W+1:DATA_W+2];

    assign pos_bad  = CMPW'(in_pos) >= CMPW'(r_count);
    assign out_free = !r_ovalid || m_axis_tready;

    // The one shared index unit: step the working index up or down by one.
    assign idx_step = idx_dec ? (r_idx - AW'(1)) : (r_idx + AW'(1));

    ple_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_val    <= n_val;
        r_status <= n_status;
        r_rdval  <= n_rdval;
        r_odata  <= n_odata;
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_val     = r_val;
        n_status  = r_status;
        n_rdval   = r_rdval;
        n_ovalid  = r_ovalid;
        n_odata   = r_odata;
        mem_we    = 1'b0;
        mem_waddr = r_idx;
        mem_wdata = mem_rdata;
        mem_raddr = r_idx;
        idx_dec   = 1'b0;

        if (r_ovalid && m_axis_tready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                n_status = ST_OK;
                n_rdval  = '0;
                n_val    = in_val;
                mem_raddr = AW'(in_pos);
                if (s_axis_tvalid) begin
                    n_state = S_FINISH;
                    unique case (in_op)
                        OP_INSERT: begin
                            if (r_count >= CW'(DEPTH)) begin
                                n_status = ST_FULL;
                            end else if (r_count == '0) begin
                                mem_we    = 1'b1;
                                mem_waddr = '0;
                                mem_wdata = in_val;
                                n_count   = r_count + CW'(1);
                            end else begin
                                // The working index is the destination of the last entry.
                                n_idx   = AW'(r_count);
                                n_state = S_INS_RD;
                            end
                        end
                        OP_READ: begin
                            if (pos_bad) begin
                                n_status = ST_INVALID;
                                n_rdval  = '1;
                            end else begin
                                n_state = S_RD_WAIT;
                            end
                        end
                        OP_DELETE: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else if (pos_bad) begin
                                n_status = ST_INVALID;
                            end else if (CW'(in_pos) == r_count - CW'(1)) begin
                                // Deleting the last entry moves nothing.
                                n_count = r_count - CW'(1);
                            end else begin
                                n_idx   = AW'(in_pos);
                                n_state = S_DEL_RD;
                            end
                        end
                        OP_NONE: begin
                            n_status = ST_OK;
                        end
                        default: begin
                            n_status = ST_OK;
                        end
                    endcase
                end
            end
            S_INS_RD: begin
                idx_dec   = 1'b1;
                mem_raddr = idx_step;
                n_state   = S_INS_WR;
            end
            S_INS_WR: begin
                // Move the entry one place toward the back, walking to the front.
                mem_we    = 1'b1;
                mem_waddr = r_idx;
                idx_dec   = 1'b1;
                if (r_idx == AW'(1)) begin
                    n_state = S_INS_TOP;
                end else begin
                    n_idx   = idx_step;
                    n_state = S_INS_RD;
                end
            end
            S_INS_TOP: begin
                mem_we    = 1'b1;
                mem_waddr = '0;
                mem_wdata = r_val;
                n_count   = r_count + CW'(1);
                n_state   = S_FINISH;
            end
            S_DEL_RD: begin
                mem_raddr = idx_step;
                n_state   = S_DEL_WR;
            end
            S_DEL_WR: begin
                // Pull the following entry forward into the gap.
                mem_we    = 1'b1;
                mem_waddr = r_idx;
                n_idx     = idx_step;
                if (CW'(r_idx) + CW'(2) == r_count) begin
                    n_count = r_count - CW'(1);
                    n_state = S_FINISH;
                end else begin
                    n_state = S_DEL_RD;
                end
            end
            S_RD_WAIT: begin
                n_rdval = mem_rdata;
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_odata  = {1'b0, CNT_OUT_W'(r_count), r_rdval, r_status};
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

endmodule

/* sv/ple_checker.sv */
// Port-level checker of the positional list engine, bound to the top level.
`timescale 1ns / 1ps

module ple_checker #(
    parameter int DEPTH = ple_pkg::PLE_DEPTH
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [ple_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import ple_pkg::*;

    logic [1:0]           out_status;
    logic [CNT_OUT_W-1:0] out_count;

    assign out_status = m_axis_tdata[1:0];
    assign out_count  = m_axis_tdata[DATA_W+CNT_OUT_W+1:DATA_W+2];

    // A waiting result keeps its contents until it is taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // An accepted item never yields its result in the very next cycle.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
        else $error("result appeared too early");

    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && out_status == ST_FULL |-> out_count == CNT_OUT_W'(DEPTH))
        else $error("full status with a list that is not full");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && out_status == ST_EMPTY |-> out_count == '0)
        else $error("empty status with a nonzero count");

    // Reset drops any result that was waiting.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

bind positional_list_engine ple_checker #(.DEPTH(DEPTH)) u_ple_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

/* tb/tb_positional_list_engine.sv */
// Testbench of the positional list engine, checking every result against a list predictor.
`timescale 1ns / 1ps

module tb_positional_list_engine;

    import ple_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int PHASE_ITEMS    = 150;
    localparam logic [DATA_W-1:0] NO_ENTRY = 32'hFFFF_FFFF;

    typedef struct packed {
        t_status               status;
        logic [DATA_W-1:0]     read_value;
        logic [CNT_OUT_W-1:0]  entry_count;
    } t_list_result;

    // Holds its own copy of the list and the results still owed by the block.
    class list_scoreboard;
        logic [DATA_W-1:0] words [PLE_DEPTH];
        int unsigned       held;
        t_list_result      owed_q[$];
        int                mismatches;

        function new();
            held       = 0;
            mismatches = 0;
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        // Apply one accepted item to the list copy and queue what it must return.
        function void note_item(t_opcode op, logic [DATA_W-1:0] val, logic [POS_W-1:0] pos);
            t_list_result res;
            res.status     = ST_OK;
            res.read_value = '0;
            case (op)
                OP_INSERT: begin
                    if (held >= PLE_DEPTH) begin
                        res.status = ST_FULL;
                    end else begin
                        for (int i = held; i > 0; i--) words[i] = words[i-1];
                        words[0] = val;
                        held++;
                    end
                end
                OP_READ: begin
                    if (pos >= held) begin
                        res.status     = ST_INVALID;
                        res.read_value = NO_ENTRY;
                    end else begin
                        res.read_value = words[pos];
                    end
                end
                OP_DELETE: begin
                    if (held == 0) begin
                        res.status = ST_EMPTY;
                    end else if (pos >= held) begin
                        res.status = ST_INVALID;
                    end else begin
                        for (int i = pos; i < held - 1; i++) words[i] = words[i+1];
                        held--;
                    end
                end
                default: ;
            endcase
            res.entry_count = held[CNT_OUT_W-1:0];
            owed_q.push_back(res);
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] tdata);
            t_list_result want;
            t_list_result got;
            got.status      = t_status'(tdata[1:0]);
            got.read_value  = tdata[33:2];
            got.entry_count = tdata[38:34];
            if (owed_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result with none owed: status %0d value %h count %0d",
                             $realtime, got.status, got.read_value, got.entry_count);
                return;
            end
            want = owed_q.pop_front();
            if (got !== want || tdata[39] !== 1'b0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"%0t: wrong result: status %0d/%0d value %h/%h ",
                              "count %0d/%0d (expected/actual)"}, $realtime,
                             want.status, got.status, want.read_value, got.read_value,
                             want.entry_count, got.entry_count);
            end
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    list_scoreboard sb = new();
    int src_idle_pct = 16;
    int snk_idle_pct = 47;
    int quiet_cycles = 0;

    positional_list_engine dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    // Ends the run when neither side has moved an item for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance with
    // tvalid still high, so a following item that draws no idle keeps it up without a dip.
    task automatic send_item(t_opcode op, logic [DATA_W-1:0] val, logic [POS_W-1:0] pos);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tdata  <= {2'b00, pos, val, op};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_item(op, val, pos);
        @(negedge i_clk);
    endtask

    task automatic send_random_item(int insert_pct);
        int                roll;
        t_opcode           op;
        logic [DATA_W-1:0] val;
        logic [POS_W-1:0]  pos;
        roll = $urandom_range(0, 99);
        if (roll < 3)
            op = OP_NONE;
        else if (roll < 3 + insert_pct)
            op = OP_INSERT;
        else if ($urandom_range(0, 1))
            op = OP_READ;
        else
            op = OP_DELETE;
        case ($urandom_range(0, 9))
            0:       val = 32'h8000_0000;
            1:       val = 32'h7FFF_FFFF;
            2:       val = NO_ENTRY;
            default: val = $urandom;
        endcase
        // Most positions land inside the list so reads and deletes do real work.
        if (sb.held > 0 && $urandom_range(0, 99) < 80)
            pos = $urandom_range(0, sb.held - 1);
        else
            pos = $urandom_range(0, PLE_DEPTH - 1);
        send_item(op, val, pos);
    endtask

    initial begin
        int insert_pct;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Empty list cases, the unused opcode, value extremes, edges of the range.
        send_item(OP_READ,   32'h0, 4'd0);
        send_item(OP_DELETE, 32'h0, 4'd15);
        send_item(OP_NONE,   32'hFFFF_FFFF, 4'd15);
        send_item(OP_INSERT, 32'h7FFF_FFFF, 4'd0);
        send_item(OP_INSERT, 32'h8000_0000, 4'd15);
        send_item(OP_INSERT, 32'hFFFF_FFFF, 4'd7);
        send_item(OP_INSERT, 32'h0000_0000, 4'd0);
        send_item(OP_READ,   32'h0, 4'd0);
        send_item(OP_READ,   32'h0, 4'd3);
        send_item(OP_READ,   32'h0, 4'd4);
        send_item(OP_READ,   32'h0, 4'd15);
        send_item(OP_DELETE, 32'h0, 4'd5);
        send_item(OP_DELETE, 32'h0, 4'd3);
        send_item(OP_DELETE, 32'h0, 4'd0);
        send_item(OP_READ,   32'h0, 4'd1);
        send_item(OP_DELETE, 32'h0, 4'd1);
        send_item(OP_DELETE, 32'h0, 4'd0);

        for (int phase = 0; phase < 3; phase++) begin
            if (phase == 1) begin
                src_idle_pct = 47;
                snk_idle_pct = 16;
            end else if (phase == 2) begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            insert_pct = 40;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // Swing between filling and draining so the full list is reached often.
                if (k % 25 == 0) begin
                    case ($urandom_range(0, 2))
                        0:       insert_pct = 75;
                        1:       insert_pct = 20;
                        default: insert_pct = 45;
                    endcase
                end
                send_random_item(insert_pct);
            end
        end
        s_axis_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

/* files.f */
sv/ple_pkg.sv
sv/ple_mem.sv
sv/positional_list_engine.sv
sv/ple_checker.sv
tb/tb_positional_list_engine.sv
